// ===== hdl/kbd_pkg.sv =====
// Shared constants, types and helpers for the keyed box downsampler.
`timescale 1ns / 1ps
package kbd_pkg;

   localparam int MAX_BLOCK_SHIFT = 4;
   localparam int LANE_W          = 8;
   localparam int NUM_LANES       = 4;
   localparam int DIV_LANES       = 3;
   localparam int PIXEL_W         = 32;
   localparam int FORMAT_W        = 2;
   localparam int SHIFT_W         = 3;
   localparam int KEY_W           = 16;
   localparam int CNT_W           = 2 * MAX_BLOCK_SHIFT + 1;
   localparam int SUM_W           = LANE_W + 2 * MAX_BLOCK_SHIFT;
   localparam int STEP_W          = $clog2(LANE_W);
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W          = 4;
   localparam int DATA_W          = 32;
   localparam int REG_IDX_W       = ADDR_W - 2;

   localparam logic [FORMAT_W-1:0] FMT_RGB565_KEYED = 2'd0;
   localparam logic [FORMAT_W-1:0] FMT_RGBA_PLAIN   = 2'd1;
   localparam logic [FORMAT_W-1:0] FMT_RGB24_KEYED  = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_FORMAT = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_KEY    = 2'd2;

   localparam logic [FORMAT_W-1:0] FORMAT_RESET = FMT_RGB565_KEYED;
   localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 3'd2;
   localparam logic [KEY_W-1:0]    KEY_RESET    = 16'hF81F;
   localparam logic [23:0]         KEY_RGB24    = 24'hFF00FF;

   typedef struct packed {
      logic [FORMAT_W-1:0] pixel_format;
      logic [SHIFT_W-1:0]  block_shift;
      logic [KEY_W-1:0]    key_color;
   } cfg_type;

   typedef struct packed {
      logic [NUM_LANES-1:0][LANE_W-1:0] lane;
      logic                             opaque;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic accumulating;
      logic dividing;
      logic delivering;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_ACCUM   = 3'b001,
      ST_DIVIDE  = 3'b010,
      ST_DELIVER = 3'b100
   } back_state_type;

   function automatic logic is_keyed(input logic [FORMAT_W-1:0] fmt);
      return (fmt == FMT_RGB565_KEYED) || (fmt == FMT_RGB24_KEYED);
   endfunction

endpackage

// ===== hdl/kbd_ifs.sv =====
// Pixel and result channel interfaces.
`timescale 1ns / 1ps
interface kbd_req_if;
   logic                        valid;
   logic                        ready;
   logic [kbd_pkg::PIXEL_W-1:0] source_pixel;

   modport source (output valid, output source_pixel, input ready);
   modport sink   (input valid, input source_pixel, output ready);
endinterface

interface kbd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [kbd_pkg::LANE_W-1:0] lane_zero;
   logic [kbd_pkg::LANE_W-1:0] lane_one;
   logic [kbd_pkg::LANE_W-1:0] lane_two;
   logic [kbd_pkg::LANE_W-1:0] lane_three;

   modport source (output valid, output lane_zero, output lane_one, output lane_two,
                   output lane_three, input ready);
   modport sink   (input valid, input lane_zero, input lane_one, input lane_two,
                   input lane_three, output ready);
endinterface

// ===== hdl/kbd_csr.sv =====
// APB-style configuration register file.
`timescale 1ns / 1ps
module kbd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [kbd_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [kbd_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [kbd_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output kbd_pkg::cfg_type            cfg
);

   kbd_pkg::cfg_type                  cfg_ff, cfg_in;
   logic [kbd_pkg::REG_IDX_W-1:0]     reg_idx;
   logic                              wr_en;

   assign reg_idx    = csr_paddr[kbd_pkg::ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            kbd_pkg::REG_FORMAT: cfg_in.pixel_format = csr_pwdata[kbd_pkg::FORMAT_W-1:0];
            kbd_pkg::REG_SHIFT:  cfg_in.block_shift  = csr_pwdata[kbd_pkg::SHIFT_W-1:0];
            kbd_pkg::REG_KEY:    cfg_in.key_color    = csr_pwdata[kbd_pkg::KEY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         kbd_pkg::REG_FORMAT: csr_prdata = kbd_pkg::DATA_W'(cfg_ff.pixel_format);
         kbd_pkg::REG_SHIFT:  csr_prdata = kbd_pkg::DATA_W'(cfg_ff.block_shift);
         kbd_pkg::REG_KEY:    csr_prdata = kbd_pkg::DATA_W'(cfg_ff.key_color);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format <= kbd_pkg::FORMAT_RESET;
         cfg_ff.block_shift  <= kbd_pkg::SHIFT_RESET;
         cfg_ff.key_color    <= kbd_pkg::KEY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/kbd_front.sv =====
// Front end: takes pixel beats, applies the key test and lane expansion, queues them.
`timescale 1ns / 1ps
module kbd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  kbd_pkg::cfg_type           cfg,
   kbd_req_if.sink                    req,
   output kbd_pkg::entry_type         q_entry,
   output logic                       q_valid,
   input  logic                       q_ready,
   output kbd_pkg::queue_status_type  status
);

   kbd_pkg::entry_type             entry_in;
   kbd_pkg::entry_type             mem_ff [kbd_pkg::QUEUE_DEPTH];
   logic [kbd_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [kbd_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [kbd_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic [kbd_pkg::PIXEL_W-1:0]    pix;
   logic                           push, pop;

   assign pix = req.source_pixel;

   // classify under the format in force at arrival
   always_comb begin
      entry_in = '0;
      case (cfg.pixel_format)
         kbd_pkg::FMT_RGB565_KEYED: begin
            if (pix[15:0] != cfg.key_color) begin
               entry_in.lane[0] = {pix[15:11], 3'b000};
               entry_in.lane[1] = {pix[10:5], 2'b00};
               entry_in.lane[2] = {pix[4:0], 3'b000};
               entry_in.opaque  = 1'b1;
            end
         end
         kbd_pkg::FMT_RGB24_KEYED: begin
            if (pix[23:0] != kbd_pkg::KEY_RGB24) begin
               entry_in.lane[0] = pix[7:0];
               entry_in.lane[1] = pix[15:8];
               entry_in.lane[2] = pix[23:16];
               entry_in.opaque  = 1'b1;
            end
         end
         default: begin
            entry_in.lane[0] = pix[7:0];
            entry_in.lane[1] = pix[15:8];
            entry_in.lane[2] = pix[23:16];
            entry_in.lane[3] = pix[31:24];
            entry_in.opaque  = 1'b1;
         end
      endcase
   end

   assign req.ready    = (cnt_ff != kbd_pkg::QCNT_W'(kbd_pkg::QUEUE_DEPTH));
   assign q_valid      = (cnt_ff != '0);
   assign q_entry      = mem_ff[rd_ptr_ff];
   assign push         = req.valid && req.ready;
   assign pop          = q_valid && q_ready;
   assign status.full  = !req.ready;
   assign status.empty = !q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == kbd_pkg::QPTR_W'(kbd_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == kbd_pkg::QPTR_W'(kbd_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== hdl/kbd_back.sv =====
// Back end: lane accumulation, serial mean divider and result register.
`timescale 1ns / 1ps
module kbd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  kbd_pkg::cfg_type          cfg,
   input  kbd_pkg::entry_type        q_entry,
   input  logic                      q_valid,
   output logic                      q_ready,
   kbd_rsp_if.source                 rsp,
   output kbd_pkg::back_status_type  status
);

   localparam int LW = kbd_pkg::LANE_W;
   localparam int SW = kbd_pkg::SUM_W;
   localparam int CW = kbd_pkg::CNT_W;
   localparam int NL = kbd_pkg::NUM_LANES;
   localparam int DL = kbd_pkg::DIV_LANES;

   kbd_pkg::back_state_type         state_ff, state_in;
   logic [SW-1:0]                   sum_ff [NL];
   logic [SW-1:0]                   sum_in [NL];
   logic [SW-1:0]                   sum_add [NL];
   logic [LW-1:0]                   quo_ff [DL];
   logic [LW-1:0]                   quo_in [DL];
   logic [SW:0]                     diff [DL];
   logic [CW-1:0]                   count_ff, count_in, count_add;
   logic [CW-1:0]                   taken_ff, taken_in, taken_add;
   logic [SW-1:0]                   dsh_ff, dsh_in;
   logic [kbd_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                            out_valid_ff, out_valid_in;
   logic [LW-1:0]                   out_lane_ff [NL];
   logic [LW-1:0]                   out_lane_in [NL];
   logic [LW-1:0]                   result [NL];
   logic [kbd_pkg::SHIFT_W-1:0]     s_eff;
   logic [kbd_pkg::SHIFT_W:0]       two_s;
   logic [CW-1:0]                   total;
   logic                            keyed, pop, load;
   logic [CW+LW-1:0]                alpha_prod, alpha_sh;
   logic [SW:0]                     rnd [NL];
   logic [SW:0]                     rnd_sh [NL];

   always_comb begin
      if (cfg.block_shift == '0) begin
         s_eff = kbd_pkg::SHIFT_W'(1);
      end else if (cfg.block_shift > kbd_pkg::SHIFT_W'(kbd_pkg::MAX_BLOCK_SHIFT)) begin
         s_eff = kbd_pkg::SHIFT_W'(kbd_pkg::MAX_BLOCK_SHIFT);
      end else begin
         s_eff = cfg.block_shift;
      end
   end

   assign two_s   = {s_eff, 1'b0};
   assign total   = CW'(1) << two_s;
   assign keyed   = kbd_pkg::is_keyed(cfg.pixel_format);
   assign q_ready = (state_ff == kbd_pkg::ST_ACCUM);
   assign pop     = q_valid && q_ready;
   assign load    = (state_ff == kbd_pkg::ST_DELIVER) && (!out_valid_ff || rsp.ready);

   assign count_add = count_ff + CW'(q_entry.opaque);
   assign taken_add = taken_ff + 1'b1;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         sum_add[i] = sum_ff[i] + SW'(q_entry.lane[i]);
      end
      for (int i = 0; i < DL; i++) begin
         diff[i] = {1'b0, sum_ff[i]} - {1'b0, dsh_ff};
      end
   end

   // result formation: coverage alpha is 255*count = (count << 8) - count
   assign alpha_prod = {count_ff, LW'(0)} - {LW'(0), count_ff};
   assign alpha_sh   = alpha_prod >> two_s;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         rnd[i]    = {1'b0, sum_ff[i]} + ((SW + 1)'(1) << (two_s - 1'b1));
         rnd_sh[i] = rnd[i] >> two_s;
      end
      if (keyed) begin
         if (count_ff == '0) begin
            for (int i = 0; i < NL; i++) begin
               result[i] = '0;
            end
         end else begin
            for (int i = 0; i < DL; i++) begin
               result[i] = quo_ff[i];
            end
            result[NL-1] = (|alpha_sh[CW+LW-1:LW]) ? {LW{1'b1}} : alpha_sh[LW-1:0];
         end
      end else begin
         for (int i = 0; i < NL; i++) begin
            result[i] = (|rnd_sh[i][SW:LW]) ? {LW{1'b1}} : rnd_sh[i][LW-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      count_in     = count_ff;
      taken_in     = taken_ff;
      dsh_in       = dsh_ff;
      step_in      = step_ff;
      out_lane_in  = out_lane_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      unique case (state_ff)
         kbd_pkg::ST_ACCUM: begin
            if (pop) begin
               sum_in   = sum_add;
               count_in = count_add;
               taken_in = taken_add;
               if (taken_add >= total) begin
                  if (keyed) begin
                     dsh_in   = SW'({count_add, (LW - 1)'(0)});
                     step_in  = kbd_pkg::STEP_W'(LW - 1);
                     state_in = kbd_pkg::ST_DIVIDE;
                  end else begin
                     state_in = kbd_pkg::ST_DELIVER;
                  end
               end
            end
         end
         kbd_pkg::ST_DIVIDE: begin
            for (int i = 0; i < DL; i++) begin
               if (!diff[i][SW]) begin
                  sum_in[i] = diff[i][SW-1:0];
                  quo_in[i] = {quo_ff[i][LW-2:0], 1'b1};
               end else begin
                  quo_in[i] = {quo_ff[i][LW-2:0], 1'b0};
               end
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = kbd_pkg::ST_DELIVER;
            end
         end
         kbd_pkg::ST_DELIVER: begin
            if (load) begin
               out_lane_in  = result;
               out_valid_in = 1'b1;
               for (int i = 0; i < NL; i++) begin
                  sum_in[i] = '0;
               end
               count_in = '0;
               taken_in = '0;
               state_in = kbd_pkg::ST_ACCUM;
            end
         end
         default: state_in = kbd_pkg::ST_ACCUM;
      endcase
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.lane_zero  = out_lane_ff[0];
   assign rsp.lane_one   = out_lane_ff[1];
   assign rsp.lane_two   = out_lane_ff[2];
   assign rsp.lane_three = out_lane_ff[3];

   assign status.accumulating = (state_ff == kbd_pkg::ST_ACCUM);
   assign status.dividing     = (state_ff == kbd_pkg::ST_DIVIDE);
   assign status.delivering   = (state_ff == kbd_pkg::ST_DELIVER);

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      dsh_ff      <= dsh_in;
      step_ff     <= step_in;
      out_lane_ff <= out_lane_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kbd_pkg::ST_ACCUM;
         count_ff     <= '0;
         taken_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NL; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         taken_ff     <= taken_in;
         out_valid_ff <= out_valid_in;
         sum_ff       <= sum_in;
      end
   end

endmodule

// ===== hdl/keyed_box_downsampler_unit.sv =====
// Top level of the keyed box downsampler.
//
// Pixels arrive on req_bus, one beat per source pixel of a square block of
// side 2^block_shift (shift 0 acts as 1, above 4 as 4), in any scan order.
// One averaged RGBA beat leaves on rsp_bus per completed block. Registers
// (format, shift, key) sit on the csr_ APB port at byte addresses 0, 4 and
// 8; the user must write them only while idle, as the block does not
// enforce it. Throughput: one pixel per cycle while a block fills. The
// last pixel of a keyed block starts an 8-step restoring divider (one
// quotient bit per cycle, three lanes side by side) before delivery; an
// RGBA block goes straight to delivery, which loads the result register.
// A two-beat queue sits between the pixel front end and the accumulator, so
// pixels keep being taken while the divider runs, until the queue fills.
// The result register holds its beat while rsp_bus.ready is low; the next
// block accumulates behind it and waits only at its own completion.
// Reset is synchronous: it empties the queue, clears the accumulators and
// restores format 0, shift 2 and key F81F.
`timescale 1ns / 1ps
module keyed_box_downsampler_unit (
   input  logic                        clock,
   input  logic                        reset,
   kbd_req_if.sink                     req_bus,
   kbd_rsp_if.source                   rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [kbd_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [kbd_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [kbd_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   kbd_pkg::cfg_type           cfg;
   kbd_pkg::entry_type         q_entry;
   logic                       q_valid, q_ready, q_pop;
   kbd_pkg::queue_status_type  queue_status;
   kbd_pkg::back_status_type   back_status;

   kbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kbd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_bus),
      .q_entry (q_entry),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .status  (queue_status)
   );

   kbd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_entry (q_entry),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .rsp     (rsp_bus),
      .status  (back_status)
   );

   assign q_pop = q_valid && q_ready;

   a_no_pop_while_dividing: assert property (@(posedge clock) disable iff (reset)
      back_status.dividing |-> !q_pop)
      else $error("queue popped while divider busy");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(queue_status.full && queue_status.empty))
      else $error("queue reports full and empty");

   a_result_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(back_status.delivering))
      else $error("result beat raised outside delivery");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> queue_status.full)
      else $error("pixel stalled with room in queue");

endmodule

// ===== sim/keyed_box_downsampler_unit_tb.sv =====
// Self-checking testbench for keyed_box_downsampler_unit: pixel stream in, block averages out.
`timescale 1ns / 1ps
module keyed_box_downsampler_unit_tb;

   localparam logic [kbd_pkg::FORMAT_W-1:0]  FMT_SPARE     = 2'd3;
   localparam logic [kbd_pkg::REG_IDX_W-1:0] REG_UNUSED    = 2'd3;
   localparam int                            DRAIN_CYCLES  = 20;
   localparam int                            RSP_HOLD      = 400;
   localparam int                            STALL_LIMIT   = 2000;
   localparam int                            RANDOM_ITEMS  = 700;
   localparam int                            CALM_PHASE    = 3;

   typedef struct packed {
      logic [kbd_pkg::LANE_W-1:0] lane_zero;
      logic [kbd_pkg::LANE_W-1:0] lane_one;
      logic [kbd_pkg::LANE_W-1:0] lane_two;
      logic [kbd_pkg::LANE_W-1:0] lane_three;
   } rgba_beat_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [kbd_pkg::ADDR_W-1:0]   csr_paddr;
   logic [kbd_pkg::DATA_W-1:0]   csr_pwdata;
   logic [kbd_pkg::DATA_W-1:0]   csr_prdata;
   logic                         csr_pready;

   kbd_req_if req_bus ();
   kbd_rsp_if rsp_bus ();

   keyed_box_downsampler_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [kbd_pkg::FORMAT_W-1:0] cfg_format;
   logic [kbd_pkg::SHIFT_W-1:0]  cfg_shift;
   logic [kbd_pkg::KEY_W-1:0]    cfg_key;
   int                           acc_lane [4];
   int                           opaque_n;
   int                           taken_n;
   rgba_beat_type                block_avg_q [$];

   int                           error_count;
   bit                           tx_calm;
   bit                           rx_calm;
   bit                           rsp_hold_req;
   int                           hold_left;
   int                           stall_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 100) $display("%0t ns: %s", $time, msg);
   endtask

   function automatic int block_log2();
      if (cfg_shift == 0) return 1;
      if (cfg_shift > kbd_pkg::MAX_BLOCK_SHIFT) return kbd_pkg::MAX_BLOCK_SHIFT;
      return int'(cfg_shift);
   endfunction

   function automatic logic [kbd_pkg::DATA_W-1:0] reg_value(
      input logic [kbd_pkg::REG_IDX_W-1:0] idx);
      case (idx)
         kbd_pkg::REG_FORMAT: return kbd_pkg::DATA_W'(cfg_format);
         kbd_pkg::REG_SHIFT:  return kbd_pkg::DATA_W'(cfg_shift);
         default:             return kbd_pkg::DATA_W'(cfg_key);
      endcase
   endfunction

   // accumulate one accepted pixel, queue the block average when complete
   task automatic fold_pixel(input logic [kbd_pkg::PIXEL_W-1:0] px);
      int            s;
      int            alpha;
      int            half;
      int            avg [4];
      rgba_beat_type beat;
      s = block_log2();
      case (cfg_format)
         kbd_pkg::FMT_RGB565_KEYED: begin
            if (px[15:0] != cfg_key) begin
               acc_lane[0] += {px[15:11], 3'b000};
               acc_lane[1] += {px[10:5], 2'b00};
               acc_lane[2] += {px[4:0], 3'b000};
               opaque_n++;
            end
         end
         kbd_pkg::FMT_RGB24_KEYED: begin
            if (px[23:0] != kbd_pkg::KEY_RGB24) begin
               for (int i = 0; i < 3; i++) acc_lane[i] += px[8*i +: 8];
               opaque_n++;
            end
         end
         default: begin
            for (int i = 0; i < 4; i++) acc_lane[i] += px[8*i +: 8];
            opaque_n++;
         end
      endcase
      taken_n++;
      if (taken_n >= (1 << (2 * s))) begin
         if (cfg_format == kbd_pkg::FMT_RGB565_KEYED ||
             cfg_format == kbd_pkg::FMT_RGB24_KEYED) begin
            if (opaque_n == 0) begin
               avg = '{0, 0, 0, 0};
            end else begin
               alpha = (255 * opaque_n) >> (2 * s);
               for (int i = 0; i < 3; i++) avg[i] = (acc_lane[i] / opaque_n) & 8'hFF;
               avg[3] = (alpha > 255) ? 255 : alpha;
            end
         end else begin
            half = 1 << (2 * s - 1);
            for (int i = 0; i < 4; i++) begin
               avg[i] = (acc_lane[i] + half) >> (2 * s);
               if (avg[i] > 255) avg[i] = 255;
            end
         end
         beat.lane_zero  = kbd_pkg::LANE_W'(avg[0]);
         beat.lane_one   = kbd_pkg::LANE_W'(avg[1]);
         beat.lane_two   = kbd_pkg::LANE_W'(avg[2]);
         beat.lane_three = kbd_pkg::LANE_W'(avg[3]);
         block_avg_q.push_back(beat);
         acc_lane = '{0, 0, 0, 0};
         opaque_n = 0;
         taken_n  = 0;
      end
   endtask

   task automatic send_pixel(input logic [kbd_pkg::PIXEL_W-1:0] px);
      while (!tx_calm && $urandom_range(0, 99) < 16) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.source_pixel <= px;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      fold_pixel(px);
   endtask

   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (block_avg_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [kbd_pkg::REG_IDX_W-1:0] idx,
                            input logic [kbd_pkg::DATA_W-1:0]    data);
      req_bus.valid <= 1'b0;
      csr_psel      <= 1'b1;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b1;
      csr_paddr     <= {idx, 2'b00};
      csr_pwdata    <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         kbd_pkg::REG_FORMAT: cfg_format = data[kbd_pkg::FORMAT_W-1:0];
         kbd_pkg::REG_SHIFT:  cfg_shift  = data[kbd_pkg::SHIFT_W-1:0];
         kbd_pkg::REG_KEY:    cfg_key    = data[kbd_pkg::KEY_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [kbd_pkg::REG_IDX_W-1:0] idx);
      req_bus.valid <= 1'b0;
      csr_psel      <= 1'b1;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== reg_value(idx))
         report_error($sformatf("register %0d read %08h, expected %08h",
                                idx, csr_prdata, reg_value(idx)));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [kbd_pkg::PIXEL_W-1:0] make_pixel(input int key_pct);
      logic [kbd_pkg::PIXEL_W-1:0] px;
      px = $urandom();
      if ($urandom_range(0, 99) < key_pct) begin
         if (cfg_format == kbd_pkg::FMT_RGB565_KEYED) px[15:0] = cfg_key;
         else if (cfg_format == kbd_pkg::FMT_RGB24_KEYED) px[23:0] = kbd_pkg::KEY_RGB24;
      end else if ($urandom_range(0, 9) == 0) begin
         px = ($urandom_range(0, 1) != 0) ? '1 : '0;
      end
      return px;
   endfunction

   task automatic check_block_result();
      rgba_beat_type got;
      rgba_beat_type want;
      string         lane_name [4];
      lane_name = '{"lane_zero", "lane_one", "lane_two", "lane_three"};
      got = {rsp_bus.lane_zero, rsp_bus.lane_one, rsp_bus.lane_two, rsp_bus.lane_three};
      if (block_avg_q.size() == 0) begin
         report_error($sformatf("result beat %08h with no block pending", got));
      end else begin
         want = block_avg_q.pop_front();
         for (int i = 0; i < 4; i++)
            if (got[31-8*i -: 8] !== want[31-8*i -: 8])
               report_error($sformatf("%s got %02h, expected %02h",
                                      lane_name[i], got[31-8*i -: 8], want[31-8*i -: 8]));
      end
   endtask

   // result side: checks beats, drives ready, counts its own hold-off
   initial begin
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_block_result();
         if (rsp_hold_req && hold_left == 0) begin
            hold_left    = RSP_HOLD;
            rsp_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= rx_calm || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("keyed_box_downsampler_unit_tb: errors");
      $finish;
   end

   task automatic test_register_access();
      csr_check(kbd_pkg::REG_FORMAT);
      csr_check(kbd_pkg::REG_SHIFT);
      csr_check(kbd_pkg::REG_KEY);
      csr_write(kbd_pkg::REG_FORMAT, 32'hFFFF_FFFE);
      csr_write(kbd_pkg::REG_SHIFT, 32'hA5A5_A5A3);
      csr_write(kbd_pkg::REG_KEY, 32'hFFFF_0000);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      csr_check(kbd_pkg::REG_FORMAT);
      csr_check(kbd_pkg::REG_SHIFT);
      csr_check(kbd_pkg::REG_KEY);
   endtask

   task automatic test_rgb565_key();
      wait_quiet();
      csr_write(kbd_pkg::REG_FORMAT, 32'(kbd_pkg::FMT_RGB565_KEYED));
      csr_write(kbd_pkg::REG_SHIFT, 32'd1);
      csr_write(kbd_pkg::REG_KEY, 32'(kbd_pkg::KEY_RESET));
      repeat (4) send_pixel(32'hFFFF_FFFF);
      wait_quiet();
      csr_write(kbd_pkg::REG_KEY, 32'h0000_0000);
      repeat (4) send_pixel({16'($urandom()), 16'h0000});
   endtask

   task automatic test_rgb24_key();
      wait_quiet();
      csr_write(kbd_pkg::REG_FORMAT, 32'(kbd_pkg::FMT_RGB24_KEYED));
      send_pixel(32'hA5FF_00FF);
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h5AFF_FFFF);
   endtask

   task automatic test_rgba_average();
      wait_quiet();
      csr_write(kbd_pkg::REG_FORMAT, 32'(kbd_pkg::FMT_RGBA_PLAIN));
      send_pixel(32'h0000_0000);
      send_pixel(32'h0000_0000);
      send_pixel(32'h0000_0000);
      send_pixel(32'h0202_0202);
      wait_quiet();
      csr_write(kbd_pkg::REG_FORMAT, 32'(FMT_SPARE));
      repeat (3) send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0101_0101);
   endtask

   // block shrinks below the pixels already taken, format switches mid-block
   task automatic test_midblock_reconfig();
      wait_quiet();
      csr_write(kbd_pkg::REG_FORMAT, 32'(kbd_pkg::FMT_RGBA_PLAIN));
      csr_write(kbd_pkg::REG_SHIFT, 32'd2);
      repeat (6) send_pixel($urandom());
      wait_quiet();
      csr_write(kbd_pkg::REG_FORMAT, 32'(kbd_pkg::FMT_RGB24_KEYED));
      csr_write(kbd_pkg::REG_SHIFT, 32'd1);
      send_pixel(32'h3CFF_00FF);
   endtask

   task automatic test_output_backpressure();
      wait_quiet();
      csr_write(kbd_pkg::REG_FORMAT, 32'(kbd_pkg::FMT_RGBA_PLAIN));
      csr_write(kbd_pkg::REG_SHIFT, 32'd1);
      tx_calm      = 1'b1;
      rsp_hold_req = 1'b1;
      repeat (48) send_pixel($urandom());
      tx_calm = 1'b0;
   endtask

   task automatic test_random_blocks();
      int                          sent;
      int                          phase;
      int                          big_blocks;
      int                          r;
      int                          total;
      int                          n;
      int                          key_pct;
      logic [kbd_pkg::SHIFT_W-1:0] sh;
      logic [kbd_pkg::KEY_W-1:0]   key;
      sent       = 0;
      phase      = 0;
      big_blocks = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_quiet();
         csr_write(kbd_pkg::REG_FORMAT, ($urandom() & ~32'h3) | 32'($urandom_range(0, 3)));
         r = $urandom_range(0, 99);
         if (r < 40) sh = kbd_pkg::SHIFT_W'($urandom_range(0, 1));
         else if (r < 72) sh = 3'd2;
         else if (r < 92 || big_blocks >= 2) sh = 3'd3;
         else begin
            sh = kbd_pkg::SHIFT_W'($urandom_range(4, 7));
            big_blocks++;
         end
         csr_write(kbd_pkg::REG_SHIFT, ($urandom() & ~32'h7) | 32'(sh));
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0:       key = '0;
               1:       key = '1;
               2:       key = kbd_pkg::KEY_RESET;
               default: key = kbd_pkg::KEY_W'($urandom());
            endcase
            csr_write(kbd_pkg::REG_KEY, {16'($urandom()), key});
         end
         case ($urandom_range(0, 3))
            0:       key_pct = 0;
            1:       key_pct = 25;
            2:       key_pct = 50;
            default: key_pct = 100;
         endcase
         total = 1 << (2 * block_log2());
         if (total <= 4) n = total * $urandom_range(2, 6);
         else if (total <= 16) n = total * $urandom_range(2, 4);
         else if (total <= 64) n = total * $urandom_range(1, 2);
         else n = total;
         if ($urandom_range(0, 3) == 0) n += $urandom_range(1, total - 1);
         tx_calm = (phase == CALM_PHASE);
         rx_calm = (phase == CALM_PHASE);
         repeat (n) send_pixel(make_pixel(key_pct));
         tx_calm = 1'b0;
         rx_calm = 1'b0;
         sent += n;
         phase++;
      end
   endtask

   initial begin
      reset        <= 1'b1;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.source_pixel <= '0;
      error_count  = 0;
      tx_calm      = 1'b0;
      rx_calm      = 1'b0;
      rsp_hold_req = 1'b0;
      cfg_format   = kbd_pkg::FORMAT_RESET;
      cfg_shift    = kbd_pkg::SHIFT_RESET;
      cfg_key      = kbd_pkg::KEY_RESET;
      acc_lane     = '{0, 0, 0, 0};
      opaque_n     = 0;
      taken_n      = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_rgb565_key();
      test_rgb24_key();
      test_rgba_average();
      test_midblock_reconfig();
      test_output_backpressure();
      test_random_blocks();

      wait_quiet();
      if (block_avg_q.size() != 0)
         report_error($sformatf("%0d block results never arrived", block_avg_q.size()));
      if (error_count == 0)
         $display("keyed_box_downsampler_unit_tb: clean");
      else
         $display("keyed_box_downsampler_unit_tb: errors");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/kbd_pkg.sv
hdl/kbd_ifs.sv
hdl/kbd_csr.sv
hdl/kbd_front.sv
hdl/kbd_back.sv
hdl/keyed_box_downsampler_unit.sv
sim/keyed_box_downsampler_unit_tb.sv
